>>> hw/rtl/pat_pkg.sv
package pat_pkg;

    typedef enum logic [1:0] {
        ACT_CPU  = 2'd0,
        ACT_DMA  = 2'd1,
        ACT_LOAD = 2'd2,
        ACT_NONE = 2'd3
    } pat_action_t;

    // configuration register indexes
    localparam logic [2:0] REG_CONFIG_BITS = 3'd0;
    localparam logic [2:0] REG_PAGE_BITS   = 3'd1;
    localparam logic [2:0] REG_BANK_BIT    = 3'd2;
    localparam logic [2:0] REG_BANK_FLIP   = 3'd3;
    localparam logic [2:0] REG_BLOCK_MASK  = 3'd4;
    localparam logic [2:0] REG_BLOCK_LIMIT = 3'd5;
    localparam logic [2:0] REG_WIN_BASE    = 3'd6;

    localparam logic [8:0]  RST_CONFIG_BITS = 9'd136;
    localparam logic [5:0]  RST_PAGE_BITS   = 6'd8;
    localparam logic [2:0]  RST_BANK_BIT    = 3'd7;
    localparam logic        RST_BANK_FLIP   = 1'b1;
    localparam logic [7:0]  RST_BLOCK_MASK  = 8'h0E;
    localparam logic [7:0]  RST_BLOCK_LIMIT = 8'd8;
    localparam logic [23:0] RST_WIN_BASE    = 24'h020000;

    localparam logic [7:0]  DEFAULT_BLOCK_MASK = 8'h0E;
    localparam logic [7:0]  MIN_BLOCK_LIMIT    = 8'd1;

    localparam int MAP_DEPTH = 32;
    localparam int MAP_AW    = 5;
    localparam int XLATE_W   = 17;

    typedef struct packed {
        logic [8:0] config_bit_positions;
        logic [5:0] page_bit_positions;
        logic [2:0] bank_bit_position;
        logic       bank_flip;
    } pat_map_cfg_t;

    // position of the lowest set bit, zero for an all-zero byte
    function automatic logic [2:0] pat_ctz8(input logic [7:0] v);
        logic [2:0] pos;
        pos = 3'd0;
        for (int i = 7; i >= 0; i--)
        begin
            if (v[i])
            begin
                pos = 3'(i);
            end
        end
        return pos;
    endfunction

endpackage

>>> hw/rtl/paged_address_translator.sv
// Paged address translator: one item per cycle sustained while the master side keeps
// ready. An accepted input item goes to its result through the input register, then the
// result register, with the map lookup, block extraction and the 25-bit base add in
// between. The 32-byte map table sits in flip-flops and is written by load
// items as they pass the result stage, so a following access already sees the
// new byte; entries never loaded read as garbage. Configuration writes are taken
// at any time but are meant for an idle block.
module paged_address_translator (
    input  logic        clk,
    input  logic        rst_n,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    // address[15:0], config_value[23:16], config_written[24], write_request[25],
    // map_index[30:26], map_data[38:31], zero[39]
    input  logic [39:0] s_tdata,
    // action[1:0]
    input  logic [1:0]  s_tuser,
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    // physical_address[24:0], block_number[32:25], write_allowed[33], zero[39:34]
    output logic [39:0] m_tdata,
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data
);

    // configuration registers
    pat_pkg::pat_map_cfg_t map_cfg_reg;
    logic [7:0]            block_mask_reg;
    logic [7:0]            block_limit_reg;
    logic [23:0]           win_base_reg;

    // input stage
    logic                  in_vld_reg, in_vld_next;
    pat_pkg::pat_action_t  in_action_reg;
    logic [15:0]           in_address_reg;
    logic [7:0]            in_cfg_reg;
    logic                  in_written_reg;
    logic                  in_wr_reg;
    logic [4:0]            in_midx_reg;
    logic [7:0]            in_mdata_reg;

    // result stage
    logic                  out_vld_reg, out_vld_next;
    logic [24:0]           out_phys_reg, out_phys_next;
    logic [7:0]            out_blk_reg, out_blk_next;
    logic                  out_allowed_reg, out_allowed_next;

    logic                  s_accept;
    logic                  advance;
    logic                  map_wr_en;
    logic [7:0]            map_cfg_byte;
    logic [16:0]           xlate_addr;
    logic [7:0]            mask_eff;
    logic [7:0]            limit_eff;
    logic [7:0]            blk_raw;
    logic [7:0]            blk;
    logic [7:0]            blk_m1;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_cfg_reg.config_bit_positions <= pat_pkg::RST_CONFIG_BITS;
            map_cfg_reg.page_bit_positions   <= pat_pkg::RST_PAGE_BITS;
            map_cfg_reg.bank_bit_position    <= pat_pkg::RST_BANK_BIT;
            map_cfg_reg.bank_flip            <= pat_pkg::RST_BANK_FLIP;
            block_mask_reg                   <= pat_pkg::RST_BLOCK_MASK;
            block_limit_reg                  <= pat_pkg::RST_BLOCK_LIMIT;
            win_base_reg                     <= pat_pkg::RST_WIN_BASE;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                pat_pkg::REG_CONFIG_BITS: map_cfg_reg.config_bit_positions <= cfg_data[8:0];
                pat_pkg::REG_PAGE_BITS:   map_cfg_reg.page_bit_positions   <= cfg_data[5:0];
                pat_pkg::REG_BANK_BIT:    map_cfg_reg.bank_bit_position    <= cfg_data[2:0];
                pat_pkg::REG_BANK_FLIP:   map_cfg_reg.bank_flip            <= cfg_data[0];
                pat_pkg::REG_BLOCK_MASK:  block_mask_reg                   <= cfg_data[7:0];
                pat_pkg::REG_BLOCK_LIMIT: block_limit_reg                  <= cfg_data[7:0];
                pat_pkg::REG_WIN_BASE:    win_base_reg                     <= cfg_data;
                default: ;
            endcase
        end
    end

    // handshake
    assign advance     = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready    = !in_vld_reg || !out_vld_reg || m_tready;
    assign s_accept    = s_tvalid && s_tready;
    assign in_vld_next = s_accept ? 1'b1 : (advance ? 1'b0 : in_vld_reg);
    assign out_vld_next = advance ? 1'b1 : (m_tready ? 1'b0 : out_vld_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_action_reg  <= pat_pkg::pat_action_t'(s_tuser);
            in_address_reg <= s_tdata[15:0];
            in_cfg_reg     <= s_tdata[23:16];
            in_written_reg <= s_tdata[24];
            in_wr_reg      <= s_tdata[25];
            in_midx_reg    <= s_tdata[30:26];
            in_mdata_reg   <= s_tdata[38:31];
        end
        if (advance)
        begin
            out_phys_reg    <= out_phys_next;
            out_blk_reg     <= out_blk_next;
            out_allowed_reg <= out_allowed_next;
        end
    end

    // dma block number
    always_comb
    begin
        mask_eff  = (block_mask_reg == 8'd0) ? pat_pkg::DEFAULT_BLOCK_MASK : block_mask_reg;
        limit_eff = (block_limit_reg == 8'd0) ? pat_pkg::MIN_BLOCK_LIMIT : block_limit_reg;
        blk_raw   = (in_cfg_reg & mask_eff) >> pat_pkg::pat_ctz8(mask_eff);
        blk       = (in_written_reg && (blk_raw < limit_eff)) ? blk_raw : 8'd0;
        blk_m1    = blk - 8'd1;
    end

    // block zero goes through the map as with a zero config byte
    assign map_cfg_byte = (in_action_reg == pat_pkg::ACT_CPU) ? in_cfg_reg : 8'd0;
    assign map_wr_en    = advance && (in_action_reg == pat_pkg::ACT_LOAD);

    pat_map u_map (
        .clk        (clk),
        .wr_en      (map_wr_en),
        .wr_index   (in_midx_reg),
        .wr_data    (in_mdata_reg),
        .map_cfg    (map_cfg_reg),
        .cfg_byte   (map_cfg_byte),
        .address    (in_address_reg),
        .xlate_addr (xlate_addr)
    );

    always_comb
    begin
        out_phys_next    = 25'd0;
        out_blk_next     = 8'd0;
        out_allowed_next = 1'b1;
        case (in_action_reg)
            pat_pkg::ACT_CPU:
            begin
                out_phys_next = {8'd0, xlate_addr};
                // low 16k is write protected while config bit 0 is clear
                if (in_wr_reg && (in_address_reg[15:14] == 2'b00) && !in_cfg_reg[0])
                begin
                    out_allowed_next = 1'b0;
                end
            end
            pat_pkg::ACT_DMA:
            begin
                out_blk_next = blk;
                if (blk == 8'd0)
                begin
                    out_phys_next = {8'd0, xlate_addr};
                end
                else
                begin
                    out_phys_next = {1'b0, win_base_reg} + {1'b0, blk_m1, in_address_reg};
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {6'd0, out_allowed_reg, out_blk_reg, out_phys_reg};

    // a map load leaves an empty result
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_action_reg == pat_pkg::ACT_LOAD) |=>
            (out_vld_reg && out_phys_reg == 25'd0 && out_blk_reg == 8'd0 && out_allowed_reg))
        else $error("map load result not empty");

    // a blocked write only comes from the map path
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && !out_allowed_reg) |->
            (out_phys_reg[24:17] == 8'd0 && out_blk_reg == 8'd0))
        else $error("blocked write with non-map result");

    // a nonzero block is always under the limit
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && out_blk_reg != 8'd0) |-> (out_blk_reg < limit_eff))
        else $error("block number at or above limit");

    // input side only stalls with both stages full and the output held
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (in_vld_reg && out_vld_reg && !m_tready))
        else $error("input stalled without a full pipeline");

    // a held result is not overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && !m_tready) |=> (out_vld_reg && $stable(out_phys_reg)
            && $stable(out_blk_reg) && $stable(out_allowed_reg)))
        else $error("stalled result changed");

endmodule

>>> hw/rtl/pat_map.sv
module pat_map (
    input  logic                               clk,
    input  logic                               wr_en,
    input  logic [pat_pkg::MAP_AW-1:0]         wr_index,
    input  logic [7:0]                         wr_data,
    input  pat_pkg::pat_map_cfg_t              map_cfg,
    input  logic [7:0]                         cfg_byte,
    input  logic [15:0]                        address,
    output logic [pat_pkg::XLATE_W-1:0]        xlate_addr
);

    logic [7:0] table_mem [pat_pkg::MAP_DEPTH];

    logic [2:0]                 sel;
    logic [pat_pkg::MAP_AW-1:0] rd_index;
    logic [7:0]                 entry;
    logic [1:0]                 page;
    logic                       bank;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_mem[wr_index] <= wr_data;
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            sel[k] = cfg_byte[map_cfg.config_bit_positions[3*k +: 3]];
        end
        rd_index = {sel, address[15:14]};
        entry    = table_mem[rd_index];
        for (int k = 0; k < 2; k++)
        begin
            page[k] = entry[map_cfg.page_bit_positions[3*k +: 3]];
        end
        bank       = entry[map_cfg.bank_bit_position] ^ map_cfg.bank_flip;
        xlate_addr = {bank, page, address[13:0]};
    end

endmodule

>>> dv/xlate_checker.sv
`timescale 1ns / 100ps

module xlate_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [39:0]       s_tdata,
    input  logic [1:0]        s_tuser,
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [39:0]       m_tdata,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [23:0]       cfg_data,
    output int unsigned       pending,
    output int unsigned       errors
);

    typedef struct packed {
        logic [24:0] phys;
        logic [7:0]  blk;
        logic        allowed;
    } xlate_t;

    xlate_t translations_due[$];

    // own copy of the map table and the register file
    logic [7:0]  map_mirror [pat_pkg::MAP_DEPTH];
    logic [8:0]  sel_pos;
    logic [5:0]  page_pos;
    logic [2:0]  bank_pos;
    logic        bank_inv;
    logic [7:0]  blk_mask;
    logic [7:0]  blk_limit;
    logic [23:0] win_base;

    function automatic logic [16:0] map_lookup(input logic [15:0] addr,
                                               input logic [7:0] sel_byte);
        logic [2:0] sel;
        logic [7:0] entry;
        logic [1:0] page;
        logic       bank;
        for (int k = 0; k < 3; k++)
        begin
            sel[k] = sel_byte[sel_pos[3*k +: 3]];
        end
        entry = map_mirror[{sel, addr[15:14]}];
        for (int k = 0; k < 2; k++)
        begin
            page[k] = entry[page_pos[3*k +: 3]];
        end
        bank = entry[bank_pos] ^ bank_inv;
        return {bank, page, addr[13:0]};
    endfunction

    function automatic logic [7:0] dma_block(input logic [7:0] ch_cfg, input logic written);
        logic [7:0] msk;
        logic [7:0] lim;
        logic [7:0] blk;
        msk = (blk_mask == 8'd0) ? pat_pkg::DEFAULT_BLOCK_MASK : blk_mask;
        lim = (blk_limit == 8'd0) ? pat_pkg::MIN_BLOCK_LIMIT : blk_limit;
        if (!written)
        begin
            return 8'd0;
        end
        blk = ch_cfg & msk;
        // right-justify the masked field
        while (!msk[0])
        begin
            msk = msk >> 1;
            blk = blk >> 1;
        end
        return (blk < lim) ? blk : 8'd0;
    endfunction

    function automatic xlate_t translate(input pat_pkg::pat_action_t act,
                                         input logic [39:0] d);
        xlate_t r;
        r.phys    = '0;
        r.blk     = '0;
        r.allowed = 1'b1;
        case (act)
            pat_pkg::ACT_CPU:
            begin
                r.phys = {8'd0, map_lookup(d[15:0], d[23:16])};
                // low page is write protected unless config bit 0 is set
                if (d[25] && d[15:14] == 2'd0 && !d[16])
                begin
                    r.allowed = 1'b0;
                end
            end
            pat_pkg::ACT_DMA:
            begin
                r.blk = dma_block(d[23:16], d[24]);
                if (r.blk == 8'd0)
                begin
                    r.phys = {8'd0, map_lookup(d[15:0], 8'd0)};
                end
                else
                begin
                    r.phys = {1'b0, win_base} + {1'b0, 8'(r.blk - 8'd1), 16'd0}
                           + {9'd0, d[15:0]};
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        int unsigned errs;
        xlate_t      want;
        if (!rst_n)
        begin
            sel_pos   = pat_pkg::RST_CONFIG_BITS;
            page_pos  = pat_pkg::RST_PAGE_BITS;
            bank_pos  = pat_pkg::RST_BANK_BIT;
            bank_inv  = pat_pkg::RST_BANK_FLIP;
            blk_mask  = pat_pkg::RST_BLOCK_MASK;
            blk_limit = pat_pkg::RST_BLOCK_LIMIT;
            win_base  = pat_pkg::RST_WIN_BASE;
            translations_due.delete();
            pending <= 0;
            errors  <= 0;
        end
        else
        begin
            errs = errors;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    pat_pkg::REG_CONFIG_BITS: sel_pos   = cfg_data[8:0];
                    pat_pkg::REG_PAGE_BITS:   page_pos  = cfg_data[5:0];
                    pat_pkg::REG_BANK_BIT:    bank_pos  = cfg_data[2:0];
                    pat_pkg::REG_BANK_FLIP:   bank_inv  = cfg_data[0];
                    pat_pkg::REG_BLOCK_MASK:  blk_mask  = cfg_data[7:0];
                    pat_pkg::REG_BLOCK_LIMIT: blk_limit = cfg_data[7:0];
                    pat_pkg::REG_WIN_BASE:    win_base  = cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if (m_tvalid && m_tready)
            begin
                if (translations_due.size() == 0)
                begin
                    $error("result item with nothing expected: %0h", m_tdata);
                    errs++;
                end
                else
                begin
                    want = translations_due.pop_front();
                    if (m_tdata[24:0] !== want.phys)
                    begin
                        $error("physical_address: expected %0h, got %0h",
                               want.phys, m_tdata[24:0]);
                        errs++;
                    end
                    if (m_tdata[32:25] !== want.blk)
                    begin
                        $error("block_number: expected %0h, got %0h",
                               want.blk, m_tdata[32:25]);
                        errs++;
                    end
                    if (m_tdata[33] !== want.allowed)
                    begin
                        $error("write_allowed: expected %0h, got %0h",
                               want.allowed, m_tdata[33]);
                        errs++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                translations_due.insert(translations_due.size(),
                                        translate(pat_pkg::pat_action_t'(s_tuser), s_tdata));
                if (pat_pkg::pat_action_t'(s_tuser) == pat_pkg::ACT_LOAD)
                begin
                    map_mirror[s_tdata[30:26]] = s_tdata[38:31];
                end
            end
            pending <= translations_due.size();
            errors  <= errs;
        end
    end

endmodule

>>> dv/tb.sv
`timescale 1ns / 100ps

module tb;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic [39:0] s_tdata   = '0;
    logic [1:0]  s_tuser   = '0;
    logic        m_tready  = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [23:0] cfg_data  = '0;
    logic        s_tready;
    logic        m_tvalid;
    logic [39:0] m_tdata;
    logic        cfg_ready;

    int unsigned pending;
    int unsigned errors;
    int unsigned steady_items = 0;
    int unsigned stall_left   = 0;
    int unsigned calm_left    = 0;

    always #1 clk = ~clk;

    paged_address_translator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    xlate_checker chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pending   (pending),
        .errors    (errors)
    );

    // mostly short gaps, now and then a long one
    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 30);
    endfunction

    function automatic logic [39:0] pack_item(input logic [15:0] addr, input logic [7:0] cfg,
                                              input logic written, input logic wr,
                                              input logic [4:0] midx, input logic [7:0] mdata);
        return {1'b0, mdata, midx, wr, written, cfg, addr};
    endfunction

    // receiver stalls, with calm stretches of steady ready
    always @(posedge clk)
    begin
        if (calm_left != 0)
        begin
            calm_left <= calm_left - 1;
            m_tready  <= 1'b1;
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
            case ($urandom_range(0, 19))
                0:       calm_left  <= $urandom_range(20, 80);
                1, 2, 3: stall_left <= gap_len();
                default:
                begin
                end
            endcase
        end
    end

    task automatic send_item(input pat_pkg::pat_action_t act, input logic [39:0] body);
        int unsigned gap;
        if (steady_items != 0)
        begin
            steady_items--;
            gap = 0;
        end
        else
        begin
            gap = gap_len();
            if ($urandom_range(0, 19) == 0)
            begin
                steady_items = $urandom_range(10, 40);
            end
        end
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= body;
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [23:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic program_regs(input logic [8:0] sel_pos, input logic [5:0] page_pos,
                                input logic [2:0] bank_pos, input logic bank_inv,
                                input logic [7:0] blk_mask, input logic [7:0] blk_limit,
                                input logic [23:0] base);
        write_reg(pat_pkg::REG_CONFIG_BITS, {15'd0, sel_pos});
        write_reg(pat_pkg::REG_PAGE_BITS,   {18'd0, page_pos});
        write_reg(pat_pkg::REG_BANK_BIT,    {21'd0, bank_pos});
        write_reg(pat_pkg::REG_BANK_FLIP,   {23'd0, bank_inv});
        write_reg(pat_pkg::REG_BLOCK_MASK,  {16'd0, blk_mask});
        write_reg(pat_pkg::REG_BLOCK_LIMIT, {16'd0, blk_limit});
        write_reg(pat_pkg::REG_WIN_BASE,    base);
    endtask

    // block extraction corners under the current mask and limit
    task automatic dma_corners();
        send_item(pat_pkg::ACT_DMA, pack_item(16'($urandom), 8'h00, 1'b1, 1'b0,
                                              5'($urandom), 8'($urandom)));
        send_item(pat_pkg::ACT_DMA, pack_item(16'($urandom), 8'hFF, 1'b1, 1'b1,
                                              5'($urandom), 8'($urandom)));
        send_item(pat_pkg::ACT_DMA, pack_item(16'hFFFF, 8'hAA, 1'b1, 1'b0,
                                              5'($urandom), 8'($urandom)));
        send_item(pat_pkg::ACT_DMA, pack_item(16'h0000, 8'h55, 1'b1, 1'b1,
                                              5'($urandom), 8'($urandom)));
        send_item(pat_pkg::ACT_DMA, pack_item(16'($urandom), 8'hFF, 1'b0, 1'b1,
                                              5'($urandom), 8'($urandom)));
    endtask

    task automatic random_items(input int unsigned count);
        int unsigned r;
        pat_pkg::pat_action_t act;
        repeat (count)
        begin
            r = $urandom_range(0, 99);
            if (r < 40)
            begin
                act = pat_pkg::ACT_CPU;
            end
            else if (r < 75)
            begin
                act = pat_pkg::ACT_DMA;
            end
            else if (r < 95)
            begin
                act = pat_pkg::ACT_LOAD;
            end
            else
            begin
                act = pat_pkg::ACT_NONE;
            end
            send_item(act, pack_item(16'($urandom_range(0, 16'hFFFF)),
                                     8'($urandom_range(0, 255)),
                                     $urandom_range(0, 99) < 85, 1'($urandom_range(0, 1)),
                                     5'($urandom_range(0, 31)), 8'($urandom_range(0, 255))));
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // every map entry gets loaded before any lookup
        for (int i = 0; i < pat_pkg::MAP_DEPTH; i++)
        begin
            send_item(pat_pkg::ACT_LOAD,
                      pack_item(16'($urandom), 8'($urandom), 1'($urandom), 1'($urandom),
                                5'(i),
                                (i == 0) ? 8'h00 :
                                (i == pat_pkg::MAP_DEPTH - 1) ? 8'hFF : 8'($urandom)));
        end

        // write protect and address extremes under reset settings
        send_item(pat_pkg::ACT_CPU, pack_item(16'h0000, 8'h00, 1'b0, 1'b1, 5'h00, 8'h00));
        send_item(pat_pkg::ACT_CPU, pack_item(16'h0000, 8'h01, 1'b0, 1'b1, 5'h00, 8'h00));
        send_item(pat_pkg::ACT_CPU, pack_item(16'h3FFF, 8'h00, 1'b0, 1'b0, 5'h00, 8'h00));
        send_item(pat_pkg::ACT_CPU, pack_item(16'h4000, 8'h00, 1'b0, 1'b1, 5'h00, 8'h00));
        send_item(pat_pkg::ACT_CPU, pack_item(16'hFFFF, 8'hFF, 1'b1, 1'b1, 5'h1F, 8'hFF));
        send_item(pat_pkg::ACT_CPU, pack_item(16'hC000, 8'hFE, 1'b0, 1'b1, 5'h00, 8'h00));
        send_item(pat_pkg::ACT_DMA, pack_item(16'h0000, 8'h02, 1'b1, 1'b0, 5'h00, 8'h00));
        send_item(pat_pkg::ACT_DMA, pack_item(16'hFFFF, 8'h0E, 1'b1, 1'b0, 5'h00, 8'h00));
        send_item(pat_pkg::ACT_NONE, pack_item(16'hFFFF, 8'hFF, 1'b1, 1'b1, 5'h1F, 8'hFF));
        dma_corners();
        random_items(45);
        drain();

        // all zero: zero mask and zero limit take their fallback values
        program_regs(9'd0, 6'd0, 3'd0, 1'b0, 8'd0, 8'd0, 24'd0);
        dma_corners();
        random_items(45);
        drain();

        program_regs(9'h1FF, 6'h3F, 3'd7, 1'b1, 8'hFF, 8'hFF, 24'hFFFFFF);
        dma_corners();
        random_items(45);
        drain();

        repeat (4)
        begin
            program_regs(9'($urandom_range(0, 511)), 6'($urandom_range(0, 63)),
                         3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                         8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                         24'($urandom_range(0, 24'hFFFFFF)));
            dma_corners();
            random_items(45);
            drain();
        end

        if (errors == 0)
        begin
            $display("tb: done, clean");
        end
        else
        begin
            $display("tb: done, errors");
        end
        $finish;
    end

    initial
    begin
        #2000000;
        $display("tb: done, errors");
        $finish;
    end

endmodule

>>> paged_address_translator.f
hw/rtl/pat_pkg.sv
hw/rtl/pat_map.sv
hw/rtl/paged_address_translator.sv
dv/xlate_checker.sv
dv/tb.sv
